### design/consonant_ratio_quantizer_macros.svh
// Assertion macros for the consonant ratio quantizer.
`ifndef CONSONANT_RATIO_QUANTIZER_MACROS_SVH
`define CONSONANT_RATIO_QUANTIZER_MACROS_SVH

// Consequent checked in the cycle after the antecedent.
`define CRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define CRQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### design/crq_pkg.sv
// Shared types, mode codes and interval tables of the consonant ratio quantizer.
`timescale 1ns / 1ps

package crq_pkg;

    localparam int IO_W          = 22;
    localparam int FRAC_BITS_DEF = 16;

    typedef logic [1:0]               quant_mode_t;
    typedef logic signed [IO_W-1:0]   stretch_t;

    localparam quant_mode_t MODE_NONE      = 2'd0;
    localparam quant_mode_t MODE_CONSONANT = 2'd1;
    localparam quant_mode_t MODE_HARMONIC  = 2'd2;

    typedef struct packed {
        quant_mode_t mode;
        stretch_t    x;
    } crq_item_t;

    // Snap grid below 2/3: cut points and the values between them.
    localparam int LOW_CUTS  = 5;
    localparam int LOW_IDX_W = $clog2(LOW_CUTS + 1);
    localparam int unsigned LOW_CUT_NUM [LOW_CUTS]   = '{1, 3, 7, 5, 7};
    localparam int unsigned LOW_CUT_DEN [LOW_CUTS]   = '{16, 16, 24, 12, 12};
    localparam int unsigned LOW_VAL_NUM [LOW_CUTS+1] = '{0, 1, 1, 1, 1, 2};
    localparam int unsigned LOW_VAL_DEN [LOW_CUTS+1] = '{1, 8, 4, 3, 2, 3};

    // Just intervals within one octave.
    localparam int OCT_CUTS  = 7;
    localparam int OCT_IDX_W = $clog2(OCT_CUTS + 1);
    localparam int unsigned OCT_CUT_NUM [OCT_CUTS]   = '{11, 49, 31, 17, 31, 49, 11};
    localparam int unsigned OCT_CUT_DEN [OCT_CUTS]   = '{10, 40, 24, 12, 20, 30, 6};
    localparam int unsigned OCT_VAL_NUM [OCT_CUTS+1] = '{1, 6, 5, 4, 3, 8, 5, 2};
    localparam int unsigned OCT_VAL_DEN [OCT_CUTS+1] = '{1, 5, 4, 3, 2, 5, 3, 1};

endpackage

### design/crq_consonant.sv
// Consonant interval snapping of one stretch value, saturated to the output range.
`timescale 1ns / 1ps

module crq_consonant #(
    parameter int FRAC_BITS = crq_pkg::FRAC_BITS_DEF
) (
    input  crq_pkg::stretch_t x,
    output crq_pkg::stretch_t y
);

    import crq_pkg::*;

    localparam int SW   = ((IO_W > FRAC_BITS + 1) ? IO_W : FRAC_BITS + 1) + 1;
    localparam int YW   = SW + 1;
    localparam int CW   = SW + 8;
    localparam int EMAX = SW - 1 - FRAC_BITS;
    localparam int EW   = (EMAX < 1) ? 1 : $clog2(EMAX + 1);

    localparam logic signed [SW-1:0] ONE_S  = SW'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [YW-1:0] ONE_Y  = YW'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [YW-1:0] SAT_HI = YW'((64'sd1 <<< (IO_W - 1)) - 64'sd1);
    localparam logic signed [YW-1:0] SAT_LO = YW'(-(64'sd1 <<< (IO_W - 1)));

    logic signed [SW-1:0] s;
    logic                 neg;
    logic [SW-1:0]        r;
    logic                 in_low;
    logic [EW-1:0]        oct_e;
    logic [LOW_IDX_W-1:0] low_idx;
    logic [OCT_IDX_W-1:0] oct_idx;
    logic [SW-1:0]        q;
    logic signed [YW-1:0] y_mag;
    logic signed [YW-1:0] y_full;

    logic [SW-1:0] low_q [LOW_CUTS+1];
    logic [SW-1:0] oct_q [EMAX+1][OCT_CUTS+1];

    // Snap values, rounded to the nearest LSB with halves up.
    for (genvar i = 0; i <= LOW_CUTS; i++) begin : g_low
        localparam longint unsigned N = LOW_VAL_NUM[i];
        localparam longint unsigned D = LOW_VAL_DEN[i];
        localparam longint unsigned Q = ((N << (FRAC_BITS + 1)) + D) / (2 * D);
        assign low_q[i] = SW'(Q);
    end

    for (genvar e = 0; e <= EMAX; e++) begin : g_oct_e
        for (genvar i = 0; i <= OCT_CUTS; i++) begin : g_oct_v
            localparam longint unsigned N = OCT_VAL_NUM[i];
            localparam longint unsigned D = OCT_VAL_DEN[i];
            localparam longint unsigned Q = ((N << (FRAC_BITS + e)) + D) / (2 * D);
            assign oct_q[e][i] = SW'(Q);
        end
    end

    always_comb
    begin
        s   = SW'(x) + ONE_S;
        neg = s[SW-1];
        r   = neg ? $unsigned(-s) : $unsigned(s);

        in_low = (CW'(r) * CW'(3)) < (CW'(2) << FRAC_BITS);

        // Octave: e = 0 for [2/3,1), else smallest e with r <= 2^e.
        oct_e = EW'(EMAX);
        for (int j = EMAX; j >= 1; j--)
        begin
            if (r <= (SW'(1) << (FRAC_BITS + j)))
                oct_e = EW'(j);
        end
        if (r < (SW'(1) << FRAC_BITS))
            oct_e = '0;

        // Thresholds compared exactly as 2*r*den < num * 2^(frac+e), with e = 1 for the low grid.
        low_idx = LOW_IDX_W'(LOW_CUTS);
        for (int i = LOW_CUTS - 1; i >= 0; i--)
        begin
            if ((CW'(r) * CW'(2 * LOW_CUT_DEN[i])) <
                (CW'(LOW_CUT_NUM[i]) << (FRAC_BITS + 1)))
                low_idx = LOW_IDX_W'(i);
        end

        oct_idx = OCT_IDX_W'(OCT_CUTS);
        for (int i = OCT_CUTS - 1; i >= 0; i--)
        begin
            if ((CW'(r) * CW'(2 * OCT_CUT_DEN[i])) <
                (CW'(OCT_CUT_NUM[i]) << (FRAC_BITS + int'(oct_e))))
                oct_idx = OCT_IDX_W'(i);
        end

        q = in_low ? low_q[low_idx] : oct_q[oct_e][oct_idx];

        y_mag  = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        y_full = y_mag - ONE_Y;

        if (y_full > SAT_HI)
            y = stretch_t'(SAT_HI[IO_W-1:0]);
        else if (y_full < SAT_LO)
            y = stretch_t'(SAT_LO[IO_W-1:0]);
        else
            y = stretch_t'(y_full[IO_W-1:0]);
    end

endmodule

### design/crq_core.sv
// Mode selection, nearest-harmonic rounding and bypass for one stretch value.
`timescale 1ns / 1ps

module crq_core #(
    parameter int FRAC_BITS = crq_pkg::FRAC_BITS_DEF
) (
    input  crq_pkg::crq_item_t item,
    output crq_pkg::stretch_t  y
);

    import crq_pkg::*;

    localparam int HW = ((IO_W > FRAC_BITS) ? IO_W : FRAC_BITS) + 1;

    localparam logic [HW-1:0] HALF_H = HW'(1) << (FRAC_BITS - 1);
    localparam logic [HW-1:0] FRAC_MASK = (HW'(1) << FRAC_BITS) - HW'(1);
    localparam logic signed [HW:0] SAT_HI = (HW+1)'((64'sd1 <<< (IO_W - 1)) - 64'sd1);
    localparam logic signed [HW:0] SAT_LO = (HW+1)'(-(64'sd1 <<< (IO_W - 1)));

    stretch_t           y_cons;
    logic               h_neg;
    logic [HW-1:0]      h_mag;
    logic [HW-1:0]      h_q;
    logic signed [HW:0] h_full;
    stretch_t           y_harm;

    crq_consonant #(
        .FRAC_BITS (FRAC_BITS)
    ) u_consonant (
        .x (item.x),
        .y (y_cons)
    );

    // Round half away from zero on the magnitude.
    always_comb
    begin
        h_neg  = item.x[IO_W-1];
        h_mag  = h_neg ? HW'($unsigned(-(IO_W+1)'(item.x))) : HW'($unsigned(item.x));
        h_q    = (h_mag + HALF_H) & ~FRAC_MASK;
        h_full = h_neg ? -$signed({1'b0, h_q}) : $signed({1'b0, h_q});

        if (h_full > SAT_HI)
            y_harm = stretch_t'(SAT_HI[IO_W-1:0]);
        else if (h_full < SAT_LO)
            y_harm = stretch_t'(SAT_LO[IO_W-1:0]);
        else
            y_harm = stretch_t'(h_full[IO_W-1:0]);
    end

    always_comb
    begin
        case (item.mode)
            MODE_CONSONANT: y = y_cons;
            MODE_HARMONIC:  y = y_harm;
            default:        y = item.x;
        endcase
    end

endmodule

### design/consonant_ratio_quantizer.sv
// Top level of the consonant ratio quantizer: input, mode and result registers.
`timescale 1ns / 1ps
`include "consonant_ratio_quantizer_macros.svh"

// Takes one stretch value per clock and gives its quantized value on
// stretch_out via the input and result registers, with done high for exactly one
// cycle. The receiver cannot stall, so a result must be taken in the cycle
// it appears; busy stays low and start may be held high every cycle for one
// result per clock. The clock period is set by the consonant path: the
// octave search, the exact threshold compares and the interval table lookup
// between the input and result registers. quant_mode is written through
// quant_mode_we / quant_mode_wdata and is sampled with each item at start.

module consonant_ratio_quantizer #(
    parameter int FRAC_BITS = crq_pkg::FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 quant_mode_we,
    input  crq_pkg::quant_mode_t quant_mode_wdata,
    input  logic                 start,
    input  crq_pkg::stretch_t    stretch_in,
    output logic                 busy,
    output logic                 done,
    output crq_pkg::stretch_t    stretch_out
);

    import crq_pkg::*;

    quant_mode_t quant_mode_reg;
    quant_mode_t quant_mode_next;
    logic        in_valid_reg;
    logic        in_valid_next;
    crq_item_t   in_item_reg;
    crq_item_t   in_item_next;
    logic        done_reg;
    logic        done_next;
    stretch_t    out_reg;
    stretch_t    out_next;
    logic        accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    crq_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .item (in_item_reg),
        .y    (out_next)
    );

    always_comb
    begin
        quant_mode_next   = quant_mode_we ? quant_mode_wdata : quant_mode_reg;
        in_valid_next     = accept;
        in_item_next.mode = quant_mode_reg;
        in_item_next.x    = stretch_in;
        done_next         = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quant_mode_reg <= MODE_NONE;
            in_valid_reg   <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            quant_mode_reg <= quant_mode_next;
            in_valid_reg   <= in_valid_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= in_item_next;
        if (in_valid_reg)
            out_reg <= out_next;
    end

    assign done        = done_reg;
    assign stretch_out = out_reg;

    `CRQ_ASSERT_NEXT(a_accept_loads, start && !busy, in_valid_reg, "accepted item not loaded")
    `CRQ_ASSERT_NEXT(a_item_gives_result, in_valid_reg, done, "loaded item gave no result")
    `CRQ_ASSERT_NOW(a_no_spurious_result, done, $past(in_valid_reg), "result without item")
    `CRQ_ASSERT_NEXT(a_bypass_exact, in_valid_reg && (in_item_reg.mode == MODE_NONE), stretch_out == $past(in_item_reg.x), "bypass mode altered value")

endmodule
